// ===== hw/rtl/cramp_pkg.sv =====
package cramp_pkg;

    localparam int MAX_STOPS = 16;
    localparam int IDX_W     = $clog2(MAX_STOPS);
    localparam int CNT_W     = $clog2(MAX_STOPS + 1);

    localparam int POS_W     = 16;
    localparam int CH_W      = 8;
    localparam int CH_N      = 4;
    localparam int ACC_W     = CH_W + POS_W;
    localparam int CH_CNT_W  = $clog2(CH_W);
    localparam int DIV_CNT_W = $clog2(POS_W);

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_DUP   = 2'd3
    } status_t;

    // lane 0 red, 1 green, 2 blue, 3 alpha
    typedef logic [CH_N-1:0][CH_W-1:0] rgba_t;

    typedef struct packed {
        logic             op;
        logic [POS_W-1:0] offset;
        logic [CH_W-1:0]  red_in;
        logic [CH_W-1:0]  green_in;
        logic [CH_W-1:0]  blue_in;
        logic [CH_W-1:0]  alpha_in;
    } item_t;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
        logic [CH_W-1:0] alpha_out;
        status_t         status;
    } result_t;

endpackage

// ===== hw/rtl/cramp_div.sv =====
module cramp_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [cramp_pkg::POS_W-1:0] num,
    input  logic [cramp_pkg::POS_W-1:0] den,
    output logic                        done,
    output logic [cramp_pkg::POS_W-1:0] quot
);

    logic [cramp_pkg::POS_W-1:0]     rem_reg, rem_next;
    logic [cramp_pkg::POS_W-1:0]     den_reg, den_next;
    logic [cramp_pkg::POS_W-1:0]     quot_reg, quot_next;
    logic [cramp_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;

    logic [cramp_pkg::POS_W:0] rem_sh;
    logic [cramp_pkg::POS_W:0] den_ext;
    logic [cramp_pkg::POS_W:0] diff;
    logic                      ge;

    // restoring division, one quotient bit per cycle, msb first
    assign rem_sh  = {rem_reg, 1'b0};
    assign den_ext = {1'b0, den_reg};
    assign ge      = rem_sh >= den_ext;
    assign diff    = rem_sh - den_ext;

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            den_next  = den;
            quot_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[cramp_pkg::POS_W-1:0] : rem_sh[cramp_pkg::POS_W-1:0];
            quot_next = {quot_reg[cramp_pkg::POS_W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == cramp_pkg::DIV_CNT_W'(cramp_pkg::POS_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
        cnt_reg  <= cnt_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== hw/rtl/cramp_mix.sv =====
module cramp_mix
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  cramp_pkg::rgba_t            c1,
    input  cramp_pkg::rgba_t            c2,
    input  logic [cramp_pkg::POS_W-1:0] t,
    output logic                        done,
    output cramp_pkg::rgba_t            color
);

    cramp_pkg::rgba_t                                    c1_reg, c1_next;
    cramp_pkg::rgba_t                                    mag_reg, mag_next;
    logic [cramp_pkg::CH_N-1:0]                          neg_reg, neg_next;
    logic [cramp_pkg::CH_N-1:0][cramp_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic [cramp_pkg::POS_W-1:0]                         t_reg, t_next;
    logic [cramp_pkg::CH_CNT_W-1:0]                      cnt_reg, cnt_next;
    logic                                                busy_reg, busy_next;
    logic                                                done_reg, done_next;

    logic [cramp_pkg::CH_W-1:0] hi;
    logic                       rnd;

    // four lanes, one bit of |c2 - c1| per cycle, msb first
    always_comb
    begin
        c1_next   = c1_reg;
        mag_next  = mag_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        t_next    = t_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            c1_next   = c1;
            t_next    = t;
            cnt_next  = '0;
            busy_next = 1'b1;
            for (int k = 0; k < cramp_pkg::CH_N; k++)
            begin
                neg_next[k] = c2[k] < c1[k];
                mag_next[k] = (c2[k] < c1[k]) ? (c1[k] - c2[k]) : (c2[k] - c1[k]);
                acc_next[k] = '0;
            end
        end
        else if (busy_reg)
        begin
            for (int k = 0; k < cramp_pkg::CH_N; k++)
            begin
                acc_next[k] = {acc_reg[k][cramp_pkg::ACC_W-2:0], 1'b0}
                            + (mag_reg[k][cramp_pkg::CH_W-1]
                               ? {{cramp_pkg::CH_W{1'b0}}, t_reg}
                               : {cramp_pkg::ACC_W{1'b0}});
                mag_next[k] = {mag_reg[k][cramp_pkg::CH_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == cramp_pkg::CH_CNT_W'(cramp_pkg::CH_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // c1 plus the floor of the signed product (c2 - c1) * t over 65536
    always_comb
    begin
        hi  = '0;
        rnd = 1'b0;
        for (int k = 0; k < cramp_pkg::CH_N; k++)
        begin
            hi  = acc_reg[k][cramp_pkg::ACC_W-1:cramp_pkg::POS_W];
            rnd = |acc_reg[k][cramp_pkg::POS_W-1:0];
            if (neg_reg[k])
                color[k] = c1_reg[k] - hi - {{(cramp_pkg::CH_W-1){1'b0}}, rnd};
            else
                color[k] = c1_reg[k] + hi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c1_reg  <= c1_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        t_reg   <= t_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;

endmodule

// ===== hw/rtl/color_ramp_interpolator_unit.sv =====
// color ramp interpolator: sorted table of up to 16 color stops
// item channel (item_valid, item_stall, item): op 0 adds a stop at its
// sorted place, op 1 looks up the interpolated rgba color at an offset
// result channel (result_valid, result_stall, result): one beat per item,
// color plus status (ok, empty or out of range, table full, duplicate)
// items are worked one at a time; item_stall is high while one is in work,
// so the next item is taken in the cycle after the previous result is registered
// stop search walks the table one entry per cycle
// add: stop search, then the insert step (skipped for a duplicate),
// then the result register; lookup: stop search, then bit-serial
// division and bit-serial per-channel multiply; exact hits and
// out-of-range offsets finish after the search
// a finished beat sits in the result register while the next item is
// taken; if result_stall is still high when the next result is ready,
// that result waits inside until the register frees up
// reset empties the stop table and drops result_valid
module color_ramp_interpolator_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  cramp_pkg::item_t    item,
    output logic                result_valid,
    input  logic                result_stall,
    output cramp_pkg::result_t  result
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_INSERT = 6'b000100,
        S_DIV    = 6'b001000,
        S_MIX    = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [cramp_pkg::POS_W-1:0] pos_mem [cramp_pkg::MAX_STOPS];
    cramp_pkg::rgba_t            col_mem [cramp_pkg::MAX_STOPS];

    logic [cramp_pkg::CNT_W-1:0] count_reg, count_next;
    logic                        result_valid_reg, result_valid_next;
    cramp_pkg::result_t          result_reg, result_next;

    logic                        op_reg, op_next;
    logic [cramp_pkg::POS_W-1:0] offset_reg, offset_next;
    cramp_pkg::rgba_t            new_col_reg, new_col_next;
    logic [cramp_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic [cramp_pkg::CNT_W-1:0] at_reg, at_next;
    logic [cramp_pkg::POS_W-1:0] prev_pos_reg, prev_pos_next;
    cramp_pkg::rgba_t            prev_col_reg, prev_col_next;
    cramp_pkg::rgba_t            hi_col_reg, hi_col_next;
    cramp_pkg::rgba_t            res_col_reg, res_col_next;
    cramp_pkg::status_t          res_status_reg, res_status_next;

    logic [cramp_pkg::IDX_W-1:0] rd_idx;
    logic [cramp_pkg::POS_W-1:0] rd_pos;
    cramp_pkg::rgba_t            rd_col;
    logic                        scan_end;
    logic                        hit;
    logic                        above;
    logic                        full;
    logic                        ins_en;

    logic                        div_start;
    logic [cramp_pkg::POS_W-1:0] div_num;
    logic [cramp_pkg::POS_W-1:0] div_den;
    logic                        div_done;
    logic [cramp_pkg::POS_W-1:0] div_quot;
    logic                        mix_start;
    logic                        mix_done;
    cramp_pkg::rgba_t            mix_color;

    assign rd_idx   = idx_reg[cramp_pkg::IDX_W-1:0];
    assign rd_pos   = pos_mem[rd_idx];
    assign rd_col   = col_mem[rd_idx];
    assign scan_end = idx_reg == count_reg;
    assign hit      = rd_pos == offset_reg;
    assign above    = rd_pos > offset_reg;
    assign full     = count_reg == cramp_pkg::CNT_W'(cramp_pkg::MAX_STOPS);
    assign div_num  = offset_reg - prev_pos_reg;
    assign div_den  = rd_pos - prev_pos_reg;

    cramp_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    cramp_mix u_mix
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mix_start),
        .c1    (prev_col_reg),
        .c2    (hi_col_reg),
        .t     (div_quot),
        .done  (mix_done),
        .color (mix_color)
    );

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        op_next           = op_reg;
        offset_next       = offset_reg;
        new_col_next      = new_col_reg;
        idx_next          = idx_reg;
        at_next           = at_reg;
        prev_pos_next     = prev_pos_reg;
        prev_col_next     = prev_col_reg;
        hi_col_next       = hi_col_reg;
        res_col_next      = res_col_reg;
        res_status_next   = res_status_reg;
        div_start         = 1'b0;
        mix_start         = 1'b0;
        ins_en            = 1'b0;

        if (!result_stall)
            result_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    op_next         = item.op;
                    offset_next     = item.offset;
                    new_col_next    = {item.alpha_in, item.blue_in, item.green_in, item.red_in};
                    idx_next        = '0;
                    res_col_next    = '0;
                    res_status_next = cramp_pkg::ST_OK;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (op_reg == cramp_pkg::OP_ADD)
                begin
                    priority if (scan_end)
                    begin
                        at_next    = idx_reg;
                        state_next = S_INSERT;
                    end
                    else if (hit)
                    begin
                        res_status_next = cramp_pkg::ST_DUP;
                        state_next      = S_FINISH;
                    end
                    else if (above)
                    begin
                        at_next    = idx_reg;
                        state_next = S_INSERT;
                    end
                    else
                        idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    priority if (scan_end)
                    begin
                        res_status_next = cramp_pkg::ST_RANGE;
                        state_next      = S_FINISH;
                    end
                    else if (hit)
                    begin
                        res_col_next = rd_col;
                        state_next   = S_FINISH;
                    end
                    else if (above)
                    begin
                        if (idx_reg == '0)
                        begin
                            res_status_next = cramp_pkg::ST_RANGE;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            hi_col_next = rd_col;
                            div_start   = 1'b1;
                            state_next  = S_DIV;
                        end
                    end
                    else
                    begin
                        prev_pos_next = rd_pos;
                        prev_col_next = rd_col;
                        idx_next      = idx_reg + 1'b1;
                    end
                end
            end
            S_INSERT:
            begin
                if (full)
                    res_status_next = cramp_pkg::ST_FULL;
                else
                begin
                    ins_en     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                state_next = S_FINISH;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    mix_start  = 1'b1;
                    state_next = S_MIX;
                end
            end
            S_MIX:
            begin
                if (mix_done)
                begin
                    res_col_next = mix_color;
                    state_next   = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.red_out   = res_col_reg[0];
                    result_next.green_out = res_col_reg[1];
                    result_next.blue_out  = res_col_reg[2];
                    result_next.alpha_out = res_col_reg[3];
                    result_next.status    = res_status_reg;
                    result_valid_next     = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // insertion moves every entry above the slot up by one
    always_ff @(posedge clk)
    begin
        if (ins_en)
        begin
            for (int i = 0; i < cramp_pkg::MAX_STOPS; i++)
            begin
                if (cramp_pkg::CNT_W'(i) == at_reg)
                begin
                    pos_mem[i] <= offset_reg;
                    col_mem[i] <= new_col_reg;
                end
                else if (i > 0 && cramp_pkg::CNT_W'(i) > at_reg)
                begin
                    pos_mem[i] <= pos_mem[(i > 0) ? i - 1 : 0];
                    col_mem[i] <= col_mem[(i > 0) ? i - 1 : 0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg     <= result_next;
        op_reg         <= op_next;
        offset_reg     <= offset_next;
        new_col_reg    <= new_col_next;
        idx_reg        <= idx_next;
        at_reg         <= at_next;
        prev_pos_reg   <= prev_pos_next;
        prev_col_reg   <= prev_col_next;
        hi_col_reg     <= hi_col_next;
        res_col_reg    <= res_col_next;
        res_status_reg <= res_status_next;
    end

    assign item_stall   = state_reg != S_IDLE;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== dv/color_ramp_checker.sv =====
`timescale 1ns / 100ps

module color_ramp_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_stall,
    input  cramp_pkg::item_t   item,
    input  logic               result_valid,
    input  logic               result_stall,
    input  cramp_pkg::result_t result,
    output int                 errors,
    output int                 outstanding,
    output int                 beats_checked
);

    logic [cramp_pkg::POS_W-1:0] stop_pos [cramp_pkg::MAX_STOPS];
    cramp_pkg::rgba_t            stop_rgba [cramp_pkg::MAX_STOPS];
    int                          stop_total;
    cramp_pkg::result_t          ramp_results_due [$];
    cramp_pkg::result_t          due;

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("mismatch on %s at beat %0d: expected %0h, got %0h",
                 what, beats_checked, want, got);
        errors++;
    endtask

    // floor of (c2 - c1) * frac / 65536 added to c1
    function automatic logic [cramp_pkg::CH_W-1:0] blend_channel(
        input logic [cramp_pkg::CH_W-1:0] c1,
        input logic [cramp_pkg::CH_W-1:0] c2,
        input int unsigned                frac);
        int diff;
        int prod;
        int mixed;
        diff = int'(c2) - int'(c1);
        prod = diff * int'(frac);
        mixed = int'(c1) + (prod >>> 16);
        return mixed[cramp_pkg::CH_W-1:0];
    endfunction

    function automatic cramp_pkg::result_t apply_ramp_op(input cramp_pkg::item_t it);
        cramp_pkg::result_t beat;
        cramp_pkg::rgba_t   shade;
        int                 i;
        int                 lo;
        int                 slot;
        logic               hit;
        int unsigned        rise;
        int unsigned        span;
        int unsigned        frac;
        beat = '0;
        shade = '0;
        hit = 1'b0;
        if (it.op == cramp_pkg::OP_ADD)
        begin
            slot = 0;
            for (i = 0; i < stop_total; i++)
            begin
                if (stop_pos[i] == it.offset)
                begin
                    hit = 1'b1;
                end
                if (stop_pos[i] < it.offset)
                begin
                    slot = i + 1;
                end
            end
            if (hit)
            begin
                beat.status = cramp_pkg::ST_DUP;
            end
            else if (stop_total >= cramp_pkg::MAX_STOPS)
            begin
                beat.status = cramp_pkg::ST_FULL;
            end
            else
            begin
                for (i = stop_total; i > slot; i--)
                begin
                    stop_pos[i] = stop_pos[i-1];
                    stop_rgba[i] = stop_rgba[i-1];
                end
                stop_pos[slot] = it.offset;
                stop_rgba[slot] = {it.alpha_in, it.blue_in, it.green_in, it.red_in};
                stop_total++;
                beat.status = cramp_pkg::ST_OK;
            end
        end
        else
        begin
            if (stop_total == 0)
            begin
                beat.status = cramp_pkg::ST_RANGE;
            end
            else if (it.offset < stop_pos[0] || it.offset > stop_pos[stop_total-1])
            begin
                beat.status = cramp_pkg::ST_RANGE;
            end
            else
            begin
                lo = 0;
                for (i = 0; i < stop_total; i++)
                begin
                    if (stop_pos[i] <= it.offset)
                    begin
                        lo = i;
                        if (stop_pos[i] == it.offset)
                        begin
                            hit = 1'b1;
                        end
                    end
                end
                if (hit || lo + 1 >= stop_total)
                begin
                    shade = stop_rgba[lo];
                end
                else
                begin
                    rise = it.offset - stop_pos[lo];
                    span = stop_pos[lo+1] - stop_pos[lo];
                    frac = (rise << 16) / span;
                    for (i = 0; i < cramp_pkg::CH_N; i++)
                    begin
                        shade[i] = blend_channel(stop_rgba[lo][i], stop_rgba[lo+1][i], frac);
                    end
                end
                beat.status = cramp_pkg::ST_OK;
            end
        end
        beat.red_out = shade[0];
        beat.green_out = shade[1];
        beat.blue_out = shade[2];
        beat.alpha_out = shade[3];
        return beat;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_results_due.delete();
            stop_total = 0;
            errors = 0;
            beats_checked = 0;
            outstanding <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (ramp_results_due.size() == 0)
                begin
                    report_mismatch("result beat with nothing expected", '0, 32'(result));
                end
                else
                begin
                    due = ramp_results_due.pop_front();
                    if (result.red_out !== due.red_out)
                    begin
                        report_mismatch("red_out", due.red_out, result.red_out);
                    end
                    if (result.green_out !== due.green_out)
                    begin
                        report_mismatch("green_out", due.green_out, result.green_out);
                    end
                    if (result.blue_out !== due.blue_out)
                    begin
                        report_mismatch("blue_out", due.blue_out, result.blue_out);
                    end
                    if (result.alpha_out !== due.alpha_out)
                    begin
                        report_mismatch("alpha_out", due.alpha_out, result.alpha_out);
                    end
                    if (result.status !== due.status)
                    begin
                        report_mismatch("status", due.status, result.status);
                    end
                end
                beats_checked++;
            end
            if (item_valid && !item_stall)
            begin
                ramp_results_due = {ramp_results_due, apply_ramp_op(item)};
            end
            outstanding <= ramp_results_due.size();
        end
    end

endmodule

// ===== dv/color_ramp_interpolator_unit_tb.sv =====
`timescale 1ns / 100ps

module color_ramp_interpolator_unit_tb;

    localparam int RANDOM_ITEMS    = 1920;
    localparam int QUIET_TAIL      = 300;
    localparam int HOLD_OFF_CYCLES = 240;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 60;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    cramp_pkg::item_t   item;
    logic               result_valid;
    logic               result_stall;
    cramp_pkg::result_t result;

    int errors;
    int outstanding;
    int beats_checked;

    bit idle_on;
    bit hold_req;
    int adds_sent;
    int lookups_sent;
    int idle_cycles;
    int n;
    int roll;
    logic [cramp_pkg::POS_W-1:0] known_offsets [$];

    color_ramp_interpolator_unit u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    color_ramp_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .item          (item),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result),
        .errors        (errors),
        .outstanding   (outstanding),
        .beats_checked (beats_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic cramp_pkg::item_t make_add(input logic [cramp_pkg::POS_W-1:0] pos,
                                                  input logic [7:0] r, input logic [7:0] g,
                                                  input logic [7:0] b, input logic [7:0] a);
        cramp_pkg::item_t it;
        it.op = cramp_pkg::OP_ADD;
        it.offset = pos;
        it.red_in = r;
        it.green_in = g;
        it.blue_in = b;
        it.alpha_in = a;
        return it;
    endfunction

    function automatic cramp_pkg::item_t make_lookup(input logic [cramp_pkg::POS_W-1:0] pos);
        cramp_pkg::item_t it;
        it.op = cramp_pkg::OP_LOOKUP;
        it.offset = pos;
        it.red_in = 8'($urandom);
        it.green_in = 8'($urandom);
        it.blue_in = 8'($urandom);
        it.alpha_in = 8'($urandom);
        return it;
    endfunction

    // 40 percent stop hits and near misses, 16 percent ends of the range, rest anywhere
    function automatic logic [cramp_pkg::POS_W-1:0] pick_offset();
        int unsigned                 pick;
        logic [cramp_pkg::POS_W-1:0] base;
        pick = $urandom_range(0, 99);
        base = known_offsets[$urandom_range(0, known_offsets.size() - 1)];
        if (pick < 25)
        begin
            return base;
        end
        else if (pick < 40)
        begin
            return $urandom_range(0, 1) ? base + 16'd1 : base - 16'd1;
        end
        else if (pick < 48)
        begin
            return cramp_pkg::POS_W'($urandom_range(0, 15));
        end
        else if (pick < 56)
        begin
            return cramp_pkg::POS_W'($urandom_range(16'hFFF0, 16'hFFFF));
        end
        return cramp_pkg::POS_W'($urandom);
    endfunction

    task automatic send_item(input cramp_pkg::item_t it);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        if (it.op == cramp_pkg::OP_ADD)
        begin
            adds_sent++;
            known_offsets = {known_offsets, it.offset};
        end
        else
        begin
            lookups_sent++;
        end
    endtask

    task automatic run_directed();
        int k;
        send_item(make_lookup(16'h0000));
        send_item(make_add(16'h8000, 8'hFF, 8'h00, 8'h80, 8'h7F));
        send_item(make_lookup(16'h8000));
        send_item(make_lookup(16'h7FFF));
        send_item(make_lookup(16'h8001));
        send_item(make_add(16'h2000, 8'h00, 8'hFF, 8'h01, 8'hFE));
        send_item(make_add(16'hE000, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_item(make_add(16'h8000, 8'h12, 8'h34, 8'h56, 8'h78));
        send_item(make_lookup(16'h5000));
        send_item(make_lookup(16'h7FFF));
        send_item(make_lookup(16'hE000));
        send_item(make_lookup(16'hE001));
        send_item(make_add(16'h9000, 8'hAA, 8'h55, 8'hAA, 8'h55));
        send_item(make_add(16'h9002, 8'h55, 8'hAA, 8'h00, 8'hFF));
        send_item(make_lookup(16'h9001));
        // fill the table, then overflow it and hit a duplicate while full
        for (k = 0; k < 10; k++)
        begin
            send_item(make_add(16'h0010 + 16'(k) * 16'h0C00, 8'($urandom), 8'($urandom),
                               8'($urandom), 8'($urandom)));
        end
        send_item(make_add(16'hFFF0, 8'h00, 8'h00, 8'h00, 8'h00));
        send_item(make_add(16'h4321, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_item(make_add(16'h8000, 8'h00, 8'h00, 8'h00, 8'h00));
    endtask

    initial
    begin
        result_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 2) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                result_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item <= '0;
        idle_on = 1'b0;
        hold_req = 1'b0;
        adds_sent = 0;
        lookups_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_on = 1'b1;
        run_directed();
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 150 == 0)
            begin
                idle_on = (n < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            end
            if (n == 600)
            begin
                hold_req = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 15)
            begin
                send_item(make_add($urandom_range(0, 1) ? pick_offset()
                                                        : cramp_pkg::POS_W'($urandom),
                                   8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
            end
            else
            begin
                send_item(make_lookup(pick_offset()));
            end
        end
        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("ran %0d items: %0d stop adds, %0d lookups; %0d result beats checked",
                 adds_sent + lookups_sent, adds_sent, lookups_sent, beats_checked);
        $display("table filled to capacity, output held off once for %0d cycles",
                 HOLD_OFF_CYCLES);
        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
